>>> hw/rtl/unique_value_set_table_core_assert.svh
// Assertion macros for the unique value set table RTL.
`ifndef UNIQUE_VALUE_SET_TABLE_CORE_ASSERT_SVH
`define UNIQUE_VALUE_SET_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UVST_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define UVST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/uvst_pkg.sv
// Package with the field widths, codes and result type of the unique value set table.
package uvst_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned COUNT_W  = 5;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  count;
  } res_t;

endpackage

>>> hw/rtl/uvst_ifs.sv
// Valid/ready channel interfaces for the request and result transfers.
interface uvst_in_if;
  import uvst_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface uvst_out_if;
  import uvst_pkg::*;

  logic                valid;
  logic                ready;
  status_e             status;
  logic [SLOT_W-1:0]   slot;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, output status, output slot, output count, input ready);
  modport sink   (input valid, input status, input slot, input count, output ready);
endinterface

>>> hw/rtl/unique_value_set_table_core.sv
// Top level of the unique value set table: sequencer, entry RAM and result register.
// A bounded set of distinct signed 32-bit values kept as a packed list in insertion
// order. Each request transfer asks to insert or delete one value and produces exactly
// one result transfer with a status, the slot concerned and the new count. One compare
// unit walks the stored entries one per cycle out of a RAM with a registered read. A
// request is accepted, the stored values are scanned up to the first match (none on an
// empty set), on a delete each later entry moves down one slot to close the gap, and the
// result goes to the output register. A delete at slot p scans only p+1 entries. The
// hand-off to the output register waits while it still holds a result that the
// downstream side has not taken. The request side is not ready while an item is in
// progress. The output register lets a finished result wait for the downstream side
// while the next request is already being taken. After reset the set is empty; the
// entry RAM needs no clearing because only the data of slots below the count is used.
`include "unique_value_set_table_core_assert.svh"

module unique_value_set_table_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  uvst_in_if.sink       in_i,
  uvst_out_if.source    out_o
);
  import uvst_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Connections between the sequencer and the entry RAM.
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  // Result handoff from the sequencer to the output register.
  logic res_valid;
  logic res_ready;
  res_t res;

  logic out_vld_q, out_vld_d;
  res_t out_res_q;

  uvst_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_mode_i   (in_i.mode),
    .in_value_i  (in_i.value),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  uvst_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The output register takes a new result whenever it is empty or its
  // current result is leaving in this cycle.
  assign res_ready = !out_vld_q || out_o.ready;
  assign out_vld_d = (res_valid && res_ready) || (out_vld_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid  = out_vld_q;
  assign out_o.status = out_res_q.status;
  assign out_o.slot   = out_res_q.slot;
  assign out_o.count  = out_res_q.count;

  // Once a request is taken, the block stays busy for at least the next cycle.
  `UVST_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready)

  // The reported count never exceeds the capacity while it fits the field.
  `UVST_ASSERT_IMPLY(a_count_bound, clk_i, rst_ni, out_o.valid, (CAPACITY > 31) || (out_o.count <= COUNT_W'(CAPACITY)))

  // A refused insert is only reported when the store is full.
  `UVST_ASSERT_IMPLY(a_full_count, clk_i, rst_ni, out_o.valid && (out_o.status == ST_FULL), out_o.count == COUNT_W'(CAPACITY))

  // Results that touch no entry carry slot zero.
  `UVST_ASSERT_IMPLY(a_slot_zero, clk_i, rst_ni, out_o.valid && (out_o.status == ST_NOTFOUND || out_o.status == ST_FULL), out_o.slot == '0)

endmodule

>>> hw/rtl/uvst_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module uvst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/uvst_ctrl.sv
// Sequencer that scans, appends and compacts the entry list through one compare unit.
module uvst_ctrl #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          in_valid_i,
  output logic                                          in_ready_o,
  input  logic                                          in_mode_i,
  input  logic signed [uvst_pkg::VALUE_W-1:0]           in_value_i,
  output logic                                          res_valid_o,
  input  logic                                          res_ready_i,
  output uvst_pkg::res_t                                res_o,
  output logic                                          ram_we_o,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] ram_waddr_o,
  output logic [uvst_pkg::VALUE_W-1:0]                  ram_wdata_o,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] ram_raddr_o,
  input  logic [uvst_pkg::VALUE_W-1:0]                  ram_rdata_i
);
  import uvst_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CNT_W-1:0]   occ_q, occ_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               mode_q, mode_d;
  logic [VALUE_W-1:0] value_q, value_d;
  status_e            status_q, status_d;
  logic [IDX_W-1:0]   slot_q, slot_d;

  logic hit;
  logic scan_last;
  logic shift_last;

  // The single comparator and the two end-of-walk checks.
  assign hit        = (ram_rdata_i == value_q);
  assign scan_last  = ((CNT_W'(idx_q) + CNT_W'(1)) == occ_q);
  assign shift_last = ((CNT_W'(idx_q) + CNT_W'(1)) >= occ_q);

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    idx_d       = idx_q;
    mode_d      = mode_q;
    value_d     = value_q;
    status_d    = status_q;
    slot_d      = slot_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = occ_q[IDX_W-1:0];
    ram_wdata_o = value_q;
    ram_raddr_o = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mode_d  = in_mode_i;
          value_d = in_value_i;
          idx_d   = '0;
          if (occ_q == '0) begin
            // Nothing to search: an insert lands in the first slot.
            state_d = S_RESP;
            slot_d  = '0;
            if (in_mode_i == MODE_INSERT) begin
              ram_we_o    = 1'b1;
              ram_waddr_o = '0;
              ram_wdata_o = in_value_i;
              occ_d       = CNT_W'(1);
              status_d    = ST_INSERTED;
            end else begin
              status_d = ST_NOTFOUND;
            end
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ram_raddr_o = idx_q + IDX_W'(1);
        if (hit) begin
          slot_d = idx_q;
          if (mode_q == MODE_INSERT) begin
            status_d = ST_PRESENT;
            state_d  = S_RESP;
          end else begin
            // The read of the following entry is already under way.
            status_d = ST_REMOVED;
            occ_d    = occ_q - CNT_W'(1);
            state_d  = scan_last ? S_RESP : S_SHIFT;
          end
        end else if (scan_last) begin
          state_d = S_RESP;
          slot_d  = '0;
          if (mode_q == MODE_INSERT) begin
            if (occ_q == CAP_CNT) begin
              status_d = ST_FULL;
            end else begin
              ram_we_o = 1'b1;
              slot_d   = occ_q[IDX_W-1:0];
              occ_d    = occ_q + CNT_W'(1);
              status_d = ST_INSERTED;
            end
          end else begin
            status_d = ST_NOTFOUND;
          end
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_SHIFT: begin
        // Entry idx+1 arrives from the RAM and moves down to idx.
        ram_raddr_o = idx_q + IDX_W'(2);
        ram_we_o    = 1'b1;
        ram_waddr_o = idx_q;
        ram_wdata_o = ram_rdata_i;
        if (shift_last) begin
          state_d = S_RESP;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    mode_q   <= mode_d;
    value_q  <= value_d;
    status_q <= status_d;
    slot_q   <= slot_d;
  end

  assign res_o.status = status_q;
  assign res_o.slot   = SLOT_W'(slot_q);
  assign res_o.count  = COUNT_W'(occ_q);

endmodule
